@@ hw/rtl/lssp_pkg.sv @@
// Shared types, widths, register indexes and reset values of the square spiral scan unit.
package lssp_pkg;

    localparam int LSSP_COORD_WIDTH = 32;
    localparam int POS_W            = 32;
    localparam int LEN_W            = 24;
    localparam int RAD_W            = 25;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_IDX_W        = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_CENTER_Z    = 3'd2,
        REG_STEP_LEN    = 3'd3,
        REG_SCAN_SIZE   = 3'd4,
        REG_LAYER_PITCH = 3'd5,
        REG_SCAN_DEPTH  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        HEAD_PX = 2'd0,
        HEAD_NY = 2'd1,
        HEAD_NX = 2'd2,
        HEAD_PY = 2'd3
    } t_heading;

    localparam logic [POS_W-1:0] RST_CENTER_X    = 32'd681574;
    localparam logic [POS_W-1:0] RST_CENTER_Y    = 32'd1612186;
    localparam logic [POS_W-1:0] RST_CENTER_Z    = 32'd543949;
    localparam logic [LEN_W-1:0] RST_STEP_LEN    = 24'd32768;
    localparam logic [LEN_W-1:0] RST_SCAN_SIZE   = 24'd196608;
    localparam logic [LEN_W-1:0] RST_LAYER_PITCH = 24'd13107;
    localparam logic [LEN_W-1:0] RST_SCAN_DEPTH  = 24'd131072;

endpackage

@@ hw/rtl/lssp_req_if.sv @@
// Request channel of the scan unit: one tick with its restart flag.
interface lssp_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

@@ hw/rtl/lssp_res_if.sv @@
// Result channel of the scan unit: one result per request, a set-point when point_valid is set.
interface lssp_res_if;
    import lssp_pkg::*;

    logic             valid;
    logic             ready;
    logic             point_valid;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [LEN_W-1:0] camera_offset;
    logic             layer_last;
    logic             scan_last;

    modport source (output valid, output point_valid, output pos_x, output pos_y,
                    output pos_z, output camera_offset, output layer_last,
                    output scan_last, input ready);
    modport sink   (input valid, input point_valid, input pos_x, input pos_y,
                    input pos_z, input camera_offset, input layer_last,
                    input scan_last, output ready);
endinterface

@@ hw/rtl/layered_square_spiral_scan_unit.sv @@
// Top level of the layered square spiral scan set-point generator.
//
//  channel   direction  payload                                         accepted when
//  i_req     in         restart                                         valid & ready
//  o_res     out        point_valid, pos_x/y/z, camera_offset,          valid & ready
//                       layer_last, scan_last
//  i_cfg_*   in         register index and write data                   i_cfg_we
//
// For every request the next spiral step is computed from the running
// state registers in one pass and lands in the result register on the accept edge.
// A request can be accepted every cycle; the result register frees up in the same
// cycle in which the sink takes its content, so a stall only holds while the sink does.
// Synchronous active-low reset restores the register defaults and leaves the scan
// finished, so ticks answer point_valid 0 until a request with restart set arrives.
module layered_square_spiral_scan_unit #(
    parameter int COORD_WIDTH = lssp_pkg::LSSP_COORD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lssp_req_if.sink                          i_req,
    lssp_res_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [lssp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lssp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lssp_pkg::*;

    // Compare width: wide enough for the sign-extended coordinate and for -radius.
    localparam int LW = (COORD_WIDTH > RAD_W + 1) ? COORD_WIDTH : RAD_W + 1;

    // Configuration registers.
    logic [POS_W-1:0] r_center_x, r_center_y, r_center_z;
    logic [LEN_W-1:0] r_step_len, r_scan_size, r_layer_pitch, r_scan_depth;

    // Running scan state.
    logic [COORD_WIDTH-1:0] r_cur_x, r_cur_y, n_cur_x, n_cur_y;
    logic [LEN_W-1:0]       r_layer_offset, n_layer_offset;
    logic [RAD_W-1:0]       r_radius, n_radius;
    t_heading               r_heading, n_heading;
    logic                   r_finished, n_finished;

    // Result register.
    logic             r_out_valid;
    logic             r_point_valid, n_point_valid;
    logic [POS_W-1:0] r_pos_x, r_pos_y, r_pos_z, n_pos_x, n_pos_y, n_pos_z;
    logic [LEN_W-1:0] r_camera_offset, n_camera_offset;
    logic             r_layer_last, r_scan_last, n_layer_last, n_scan_last;

    // State as seen after a restart request has been applied.
    logic [COORD_WIDTH-1:0] e_cur_x, e_cur_y, m_cur_x, m_cur_y;
    logic [LEN_W-1:0]       e_offset;
    logic [RAD_W-1:0]       e_radius;
    t_heading               e_heading;
    logic                   e_finished;
    logic signed [LW-1:0]   s_x, s_y, s_r;
    logic [LEN_W:0]         nxt_offset;

    logic accept;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= RST_CENTER_X;
            r_center_y    <= RST_CENTER_Y;
            r_center_z    <= RST_CENTER_Z;
            r_step_len    <= RST_STEP_LEN;
            r_scan_size   <= RST_SCAN_SIZE;
            r_layer_pitch <= RST_LAYER_PITCH;
            r_scan_depth  <= RST_SCAN_DEPTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X:    r_center_x    <= i_cfg_data;
                REG_CENTER_Y:    r_center_y    <= i_cfg_data;
                REG_CENTER_Z:    r_center_z    <= i_cfg_data;
                REG_STEP_LEN:    r_step_len    <= i_cfg_data[LEN_W-1:0];
                REG_SCAN_SIZE:   r_scan_size   <= i_cfg_data[LEN_W-1:0];
                REG_LAYER_PITCH: r_layer_pitch <= i_cfg_data[LEN_W-1:0];
                REG_SCAN_DEPTH:  r_scan_depth  <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // One spiral step. A restart request resets the scan to its first layer before its own point is made.
    always_comb begin
        e_cur_x    = r_cur_x;
        e_cur_y    = r_cur_y;
        e_offset   = r_layer_offset;
        e_radius   = r_radius;
        e_heading  = r_heading;
        e_finished = r_finished;
        if (i_req.restart) begin
            e_cur_x    = '0;
            e_cur_y    = '0;
            e_offset   = '0;
            e_radius   = RAD_W'(r_step_len);
            e_heading  = HEAD_PX;
            e_finished = 1'b0;
        end

        m_cur_x    = e_cur_x;
        m_cur_y    = e_cur_y;
        s_x        = '0;
        s_y        = '0;
        s_r        = $signed(LW'(e_radius));
        nxt_offset = {1'b0, e_offset} + {1'b0, r_layer_pitch};

        n_cur_x        = e_cur_x;
        n_cur_y        = e_cur_y;
        n_layer_offset = e_offset;
        n_radius       = e_radius;
        n_heading      = e_heading;
        n_finished     = e_finished;

        n_point_valid   = 1'b0;
        n_pos_x         = '0;
        n_pos_y         = '0;
        n_pos_z         = '0;
        n_camera_offset = '0;
        n_layer_last    = 1'b0;
        n_scan_last     = 1'b0;

        if (!e_finished) begin
            // An empty layer, or registers shrunk under a running scan, ends it silently.
            if (e_radius > {1'b0, r_scan_size} || e_offset >= r_scan_depth) begin
                n_finished = 1'b1;
            end else begin
                case (e_heading)
                    HEAD_PX: begin
                        m_cur_x = e_cur_x + COORD_WIDTH'(r_step_len);
                        s_x     = $signed(LW'($signed(m_cur_x)));
                        if (s_x >= s_r) n_heading = HEAD_NY;
                    end
                    HEAD_NY: begin
                        m_cur_y = e_cur_y - COORD_WIDTH'(r_step_len);
                        s_y     = $signed(LW'($signed(m_cur_y)));
                        if (s_y <= -s_r) n_heading = HEAD_NX;
                    end
                    HEAD_NX: begin
                        m_cur_x = e_cur_x - COORD_WIDTH'(r_step_len);
                        s_x     = $signed(LW'($signed(m_cur_x)));
                        if (s_x <= -s_r) n_heading = HEAD_PY;
                    end
                    default: begin
                        m_cur_y = e_cur_y + COORD_WIDTH'(r_step_len);
                        s_y     = $signed(LW'($signed(m_cur_y)));
                        if (s_y >= s_r) begin
                            n_heading = HEAD_PX;
                            n_radius  = e_radius + RAD_W'(r_step_len);
                        end
                    end
                endcase
                n_cur_x = m_cur_x;
                n_cur_y = m_cur_y;

                n_point_valid   = 1'b1;
                n_pos_x         = r_center_x + POS_W'($signed(m_cur_x));
                n_pos_y         = r_center_y + POS_W'($signed(m_cur_y));
                n_pos_z         = r_center_z - POS_W'(e_offset);
                n_camera_offset = e_offset;

                // The radius outgrew the scan size: this point closes the layer.
                if (n_radius > {1'b0, r_scan_size}) begin
                    n_layer_last = 1'b1;
                    if (nxt_offset >= {1'b0, r_scan_depth}) begin
                        n_scan_last = 1'b1;
                        n_finished  = 1'b1;
                    end else begin
                        n_layer_offset = nxt_offset[LEN_W-1:0];
                        n_cur_x        = '0;
                        n_cur_y        = '0;
                        n_radius       = RAD_W'(r_step_len);
                        n_heading      = HEAD_PX;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x        <= '0;
            r_cur_y        <= '0;
            r_layer_offset <= '0;
            r_radius       <= '0;
            r_heading      <= HEAD_PX;
            r_finished     <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_cur_x        <= n_cur_x;
                r_cur_y        <= n_cur_y;
                r_layer_offset <= n_layer_offset;
                r_radius       <= n_radius;
                r_heading      <= n_heading;
                r_finished     <= n_finished;
                r_out_valid    <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_point_valid   <= n_point_valid;
            r_pos_x         <= n_pos_x;
            r_pos_y         <= n_pos_y;
            r_pos_z         <= n_pos_z;
            r_camera_offset <= n_camera_offset;
            r_layer_last    <= n_layer_last;
            r_scan_last     <= n_scan_last;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.point_valid   = r_point_valid;
    assign o_res.pos_x         = r_pos_x;
    assign o_res.pos_y         = r_pos_y;
    assign o_res.pos_z         = r_pos_z;
    assign o_res.camera_offset = r_camera_offset;
    assign o_res.layer_last    = r_layer_last;
    assign o_res.scan_last     = r_scan_last;

endmodule

@@ hw/rtl/lssp_checker.sv @@
// Port-level assertions for the scan unit and the bind that attaches them.
module lssp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic                       i_point_valid,
    input logic [lssp_pkg::POS_W-1:0] i_pos_x,
    input logic [lssp_pkg::POS_W-1:0] i_pos_y,
    input logic [lssp_pkg::POS_W-1:0] i_pos_z,
    input logic [lssp_pkg::LEN_W-1:0] i_camera_offset,
    input logic                       i_layer_last,
    input logic                       i_scan_last
);
    import lssp_pkg::*;

    // The end of the scan is always a real point that also closes its layer.
    a_scan_last_closes_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_scan_last) |-> (i_layer_last && i_point_valid))
        else $error("scan_last without layer_last or point_valid");

    // A finished or empty tick carries an all-zero result.
    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_point_valid) |->
        (i_pos_x == '0 && i_pos_y == '0 && i_pos_z == '0 && i_camera_offset == '0 &&
         !i_layer_last && !i_scan_last))
        else $error("non-zero fields on a result without a point");

    // A stalled result holds its position, point_valid and layer_last.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
        (i_res_valid && $stable(i_pos_x) && $stable(i_pos_y) && $stable(i_pos_z) &&
         $stable(i_point_valid) && $stable(i_layer_last)))
        else $error("stalled result changed");

    // Reset empties the result register.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

endmodule

bind layered_square_spiral_scan_unit lssp_checker u_lssp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_point_valid   (o_res.point_valid),
    .i_pos_x         (o_res.pos_x),
    .i_pos_y         (o_res.pos_y),
    .i_pos_z         (o_res.pos_z),
    .i_camera_offset (o_res.camera_offset),
    .i_layer_last    (o_res.layer_last),
    .i_scan_last     (o_res.scan_last)
);
